>>> hdl/ubx_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// ubx_frame_parser_assert.svh
// Assertion macros shared by the frame parser modules; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef UBX_FRAME_PARSER_ASSERT_SVH
`define UBX_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold at every edge outside reset
`define UBXFP_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define UBXFP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define UBXFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define UBXFP_ASSERT_ALWAYS(label, clk, rst, cond)
`define UBXFP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define UBXFP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hdl/ubxfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxfp_pkg
// Shared constants and the result type of the frame parser.
// ----------------------------------------------------------------------------
package ubxfp_pkg;

  // sync pair that opens every frame
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // result kinds
  localparam logic [1:0] KIND_PASS    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    logic        checksum_ok;
    logic [15:0] received_checksum;
    logic [15:0] computed_checksum;
    logic        last_of_frame;
  } result_t;

endpackage

>>> hdl/ubxfp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxfp_if
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface ubxfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubxfp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  data_byte;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [15:0] byte_index;
  logic [15:0] frame_length;
  logic        checksum_ok;
  logic [15:0] received_checksum;
  logic [15:0] computed_checksum;
  logic        last_of_frame;

  modport source (
    output valid, output result_kind, output data_byte, output msg_class,
    output msg_id, output byte_index, output frame_length, output checksum_ok,
    output received_checksum, output computed_checksum, output last_of_frame,
    input ready
  );
  modport sink (
    input valid, input result_kind, input data_byte, input msg_class,
    input msg_id, input byte_index, input frame_length, input checksum_ok,
    input received_checksum, input computed_checksum, input last_of_frame,
    output ready
  );
endinterface

>>> hdl/ubx_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_frame_parser
// Byte-stream frame parser with Fletcher-8 checksum check.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and picks out frames opened by 0xB5 0x62.
// Bytes outside a frame come back out as passthrough results; sync, header
// and CK_A bytes give none; each payload byte comes out with its index,
// class, id and length; after CK_B one frame-end result carries both
// checksums and a match flag (bad frames are flagged, not dropped). A byte
// is taken every cycle: it sits in the input register while the
// phase logic and sums update, and its result then waits in a two-entry
// buffer, so a stalled output stops input only once that buffer is full.
// ----------------------------------------------------------------------------
module ubx_frame_parser (
  input  logic       clk,
  input  logic       rst,
  ubxfp_byte_if.sink     rx,
  ubxfp_result_if.source result
);

  logic               space;
  logic               push;
  ubxfp_pkg::result_t push_data;
  ubxfp_pkg::result_t out_data;

  // phase tracking and result build
  ubxfp_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .in_byte  (rx.rx_byte),
    .space    (space),
    .push     (push),
    .res      (push_data)
  );

  // result buffer
  ubxfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  // result fields onto the channel
  assign result.result_kind       = out_data.result_kind;
  assign result.data_byte         = out_data.data_byte;
  assign result.msg_class         = out_data.msg_class;
  assign result.msg_id            = out_data.msg_id;
  assign result.byte_index        = out_data.byte_index;
  assign result.frame_length      = out_data.frame_length;
  assign result.checksum_ok       = out_data.checksum_ok;
  assign result.received_checksum = out_data.received_checksum;
  assign result.computed_checksum = out_data.computed_checksum;
  assign result.last_of_frame     = out_data.last_of_frame;

endmodule

>>> hdl/ubxfp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxfp_parse
// Input byte register, frame phase tracking and Fletcher sums; builds one
// result per byte where the byte calls for one.
// ----------------------------------------------------------------------------
`include "ubx_frame_parser_assert.svh"

module ubxfp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              space,
  output logic              push,
  output ubxfp_pkg::result_t res
);

  // frame phase codes
  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CK_A    = 4'd7;
  localparam logic [3:0] PH_CK_B    = 4'd8;

  logic        held_valid;
  logic [7:0]  held_byte;
  logic [3:0]  phase, phase_next;
  logic [7:0]  class_reg, class_reg_next;
  logic [7:0]  id_reg, id_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  first_check_byte, first_check_byte_next;
  logic        has_result;
  logic        advance;
  logic [15:0] count_inc;
  logic [15:0] rx_sum;
  logic [15:0] calc_sum;
  logic [7:0]  fl_a;
  logic [7:0]  fl_b;

  assign advance  = held_valid && (!has_result || space);
  assign in_ready = !held_valid || advance;
  assign push     = advance && has_result;

  // input byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

  // running sums and derived values
  assign fl_a      = sum_a + held_byte;
  assign fl_b      = sum_b + fl_a;
  assign count_inc = payload_count + 16'd1;
  assign rx_sum    = {held_byte, first_check_byte};
  assign calc_sum  = {sum_b, sum_a};

  // phase decode and result build
  always_comb begin
    phase_next            = phase;
    class_reg_next        = class_reg;
    id_reg_next           = id_reg;
    length_reg_next       = length_reg;
    payload_count_next    = payload_count;
    sum_a_next            = sum_a;
    sum_b_next            = sum_b;
    first_check_byte_next = first_check_byte;
    has_result            = 1'b0;
    res                   = '0;
    unique case (phase)
      PH_SYNC2: begin
        if (held_byte == ubxfp_pkg::SYNC_SECOND) begin
          phase_next = PH_CLASS;
        end else if (held_byte == ubxfp_pkg::SYNC_FIRST) begin
          phase_next = PH_SYNC2;
        end else begin
          phase_next      = PH_HUNT;
          has_result      = 1'b1;
          res.result_kind = ubxfp_pkg::KIND_PASS;
          res.data_byte   = held_byte;
        end
      end
      PH_CLASS: begin
        class_reg_next = held_byte;
        sum_a_next     = held_byte;
        sum_b_next     = held_byte;
        phase_next     = PH_ID;
      end
      PH_ID: begin
        id_reg_next = held_byte;
        sum_a_next  = fl_a;
        sum_b_next  = fl_b;
        phase_next  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_reg_next = {8'h00, held_byte};
        sum_a_next      = fl_a;
        sum_b_next      = fl_b;
        phase_next      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_reg_next    = {held_byte, length_reg[7:0]};
        sum_a_next         = fl_a;
        sum_b_next         = fl_b;
        payload_count_next = '0;
        phase_next = ({held_byte, length_reg[7:0]} == 16'd0) ? PH_CK_A : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_a_next         = fl_a;
        sum_b_next         = fl_b;
        payload_count_next = count_inc;
        has_result         = 1'b1;
        res.result_kind    = ubxfp_pkg::KIND_PAYLOAD;
        res.data_byte      = held_byte;
        res.msg_class      = class_reg;
        res.msg_id         = id_reg;
        res.byte_index     = payload_count;
        res.frame_length   = length_reg;
        if (count_inc == length_reg) begin
          res.last_of_frame = 1'b1;
          phase_next        = PH_CK_A;
        end
      end
      PH_CK_A: begin
        first_check_byte_next = held_byte;
        phase_next            = PH_CK_B;
      end
      PH_CK_B: begin
        has_result            = 1'b1;
        res.result_kind       = ubxfp_pkg::KIND_END;
        res.msg_class         = class_reg;
        res.msg_id            = id_reg;
        res.frame_length      = length_reg;
        res.checksum_ok       = (rx_sum == calc_sum);
        res.received_checksum = rx_sum;
        res.computed_checksum = calc_sum;
        phase_next            = PH_HUNT;
      end
      default: begin
        // hunting, and any code never entered
        if (held_byte == ubxfp_pkg::SYNC_FIRST) begin
          phase_next = PH_SYNC2;
        end else begin
          phase_next      = PH_HUNT;
          has_result      = 1'b1;
          res.result_kind = ubxfp_pkg::KIND_PASS;
          res.data_byte   = held_byte;
        end
      end
    endcase
  end

  // frame state, updated when the held byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      class_reg        <= '0;
      id_reg           <= '0;
      length_reg       <= '0;
      payload_count    <= '0;
      sum_a            <= '0;
      sum_b            <= '0;
      first_check_byte <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      class_reg        <= class_reg_next;
      id_reg           <= id_reg_next;
      length_reg       <= length_reg_next;
      payload_count    <= payload_count_next;
      sum_a            <= sum_a_next;
      sum_b            <= sum_b_next;
      first_check_byte <= first_check_byte_next;
    end
  end

  // payload phase only with a nonzero length and the count still short of it
  `UBXFP_ASSERT_IMPLIES(a_payload_len, clk, rst, phase == PH_PAYLOAD, length_reg != 16'd0)
  `UBXFP_ASSERT_IMPLIES(a_payload_cnt, clk, rst, phase == PH_PAYLOAD, payload_count < length_reg)
  // a stalled byte stays put in the input register
  `UBXFP_ASSERT_NEXT(a_hold_byte, clk, rst, held_valid && !advance, held_valid && $stable(held_byte))

endmodule

>>> hdl/ubxfp_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxfp_out_buf
// Two-entry result buffer; decouples the parser from output back-pressure.
// ----------------------------------------------------------------------------
`include "ubx_frame_parser_assert.svh"

module ubxfp_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ubxfp_pkg::result_t push_data,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output ubxfp_pkg::result_t out_data
);

  ubxfp_pkg::result_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `UBXFP_ASSERT_ALWAYS(a_count_max, clk, rst, count <= 2'd2)
  `UBXFP_ASSERT_IMPLIES(a_no_overfill, clk, rst, push, count != 2'd2)

endmodule

>>> tb/ubx_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_frame_checker
// Watches both channels of the frame parser, predicts every result from the
// accepted bytes and compares each result beat field by field, oldest first.
// ----------------------------------------------------------------------------
module ubx_frame_checker (
  input  logic           clk,
  input  logic           rst,
  ubxfp_byte_if          rx,
  ubxfp_result_if        result,
  input  logic           end_of_stream,
  output int             mismatch_count,
  output int             results_pending
);

  // frame phase codes
  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CK_A    = 4'd7;
  localparam logic [3:0] PH_CK_B    = 4'd8;

  logic [3:0]          phase;
  logic [7:0]          frame_class;
  logic [7:0]          frame_id;
  logic [15:0]         frame_len;
  logic [15:0]         payload_count;
  logic [7:0]          sum_a;
  logic [7:0]          sum_b;
  logic [7:0]          ck_a_byte;
  ubxfp_pkg::result_t  frame_results_q[$];
  int                  errors_seen = 0;
  bit                  leftovers_checked;

  assign mismatch_count = errors_seen;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors_seen++;
  endtask

  task automatic add_to_sums(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endtask

  // byte seen while hunting: either a first sync byte or a passthrough
  task automatic hunt_byte(input logic [7:0] b);
    ubxfp_pkg::result_t r;
    r = '0;
    if (b == ubxfp_pkg::SYNC_FIRST) begin
      phase = PH_SYNC2;
    end else begin
      phase = PH_HUNT;
      r.result_kind = ubxfp_pkg::KIND_PASS;
      r.data_byte = b;
      frame_results_q.push_back(r);
    end
  endtask

  // advance the frame state by one accepted byte
  task automatic parse_byte(input logic [7:0] b);
    ubxfp_pkg::result_t r;
    r = '0;
    case (phase)
      PH_SYNC2: begin
        if (b == ubxfp_pkg::SYNC_SECOND) phase = PH_CLASS;
        else hunt_byte(b);
      end
      PH_CLASS: begin
        sum_a = '0;
        sum_b = '0;
        frame_class = b;
        add_to_sums(b);
        phase = PH_ID;
      end
      PH_ID: begin
        frame_id = b;
        add_to_sums(b);
        phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_len = {8'h00, b};
        add_to_sums(b);
        phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_len[15:8] = b;
        add_to_sums(b);
        payload_count = '0;
        phase = (frame_len == 16'd0) ? PH_CK_A : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        add_to_sums(b);
        r.result_kind = ubxfp_pkg::KIND_PAYLOAD;
        r.data_byte = b;
        r.msg_class = frame_class;
        r.msg_id = frame_id;
        r.byte_index = payload_count;
        r.frame_length = frame_len;
        payload_count = payload_count + 16'd1;
        if (payload_count == frame_len) begin
          r.last_of_frame = 1'b1;
          phase = PH_CK_A;
        end
        frame_results_q.push_back(r);
      end
      PH_CK_A: begin
        ck_a_byte = b;
        phase = PH_CK_B;
      end
      PH_CK_B: begin
        r.result_kind = ubxfp_pkg::KIND_END;
        r.msg_class = frame_class;
        r.msg_id = frame_id;
        r.frame_length = frame_len;
        r.received_checksum = {b, ck_a_byte};
        r.computed_checksum = {sum_b, sum_a};
        r.checksum_ok = (r.received_checksum == r.computed_checksum);
        phase = PH_HUNT;
        frame_results_q.push_back(r);
      end
      default: hunt_byte(b);
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] got_v,
                             input logic [15:0] exp_v);
    if (got_v !== exp_v)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got_v, exp_v));
  endtask

  // compare one result beat with the oldest prediction
  task automatic check_result();
    ubxfp_pkg::result_t got;
    ubxfp_pkg::result_t exp_r;
    got.result_kind = result.result_kind;
    got.data_byte = result.data_byte;
    got.msg_class = result.msg_class;
    got.msg_id = result.msg_id;
    got.byte_index = result.byte_index;
    got.frame_length = result.frame_length;
    got.checksum_ok = result.checksum_ok;
    got.received_checksum = result.received_checksum;
    got.computed_checksum = result.computed_checksum;
    got.last_of_frame = result.last_of_frame;
    if (frame_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result of kind %0d", got.result_kind));
      return;
    end
    exp_r = frame_results_q.pop_front();
    check_field("result_kind", 16'(got.result_kind), 16'(exp_r.result_kind));
    check_field("data_byte", 16'(got.data_byte), 16'(exp_r.data_byte));
    check_field("msg_class", 16'(got.msg_class), 16'(exp_r.msg_class));
    check_field("msg_id", 16'(got.msg_id), 16'(exp_r.msg_id));
    check_field("byte_index", got.byte_index, exp_r.byte_index);
    check_field("frame_length", got.frame_length, exp_r.frame_length);
    check_field("checksum_ok", 16'(got.checksum_ok), 16'(exp_r.checksum_ok));
    check_field("received_checksum", got.received_checksum, exp_r.received_checksum);
    check_field("computed_checksum", got.computed_checksum, exp_r.computed_checksum);
    check_field("last_of_frame", 16'(got.last_of_frame), 16'(exp_r.last_of_frame));
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      phase = PH_HUNT;
      frame_class = '0;
      frame_id = '0;
      frame_len = '0;
      payload_count = '0;
      sum_a = '0;
      sum_b = '0;
      ck_a_byte = '0;
      frame_results_q.delete();
      leftovers_checked = 1'b0;
    end else begin
      if (rx.valid === 1'b1 && rx.ready === 1'b1)
        parse_byte(rx.rx_byte);
      if (result.valid === 1'b1 && result.ready === 1'b1)
        check_result();
      // predictions still waiting once the stream has ended
      if (end_of_stream && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (frame_results_q.size() != 0)
          report_mismatch($sformatf("%0d results never arrived",
                                    frame_results_q.size()));
      end
    end
    results_pending = frame_results_q.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives a byte stream of passthrough noise, lone sync bytes and frames with
// good and bad checksums into the frame parser under random back-pressure,
// and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic end_of_stream = 1'b0;
  int   src_idle_pct = 21;
  int   snk_idle_pct = 81;
  int   bytes_sent = 0;
  int   cycle_count = 0;
  int   mismatch_count;
  int   results_pending;

  ubxfp_byte_if   rx();
  ubxfp_result_if result();

  ubx_frame_parser i_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .result (result)
  );

  ubx_frame_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .rx              (rx),
    .result          (result),
    .end_of_stream   (end_of_stream),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    result.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // one byte beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      rx.valid <= 1'b0;
      rx.rx_byte <= 8'($urandom);
      @(negedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (rx.ready !== 1'b1);
    @(negedge clk);
    bytes_sent++;
  endtask

  // whole frame with random payload; the sync pair turns up in payloads now and then
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input bit bad_ck);
    logic [7:0] hdr [4];
    logic [7:0] sa;
    logic [7:0] sb;
    logic [7:0] d;
    sa = '0;
    sb = '0;
    hdr = '{cls, id, len[7:0], len[15:8]};
    send_byte(ubxfp_pkg::SYNC_FIRST);
    send_byte(ubxfp_pkg::SYNC_SECOND);
    foreach (hdr[k]) begin
      sa = sa + hdr[k];
      sb = sb + sa;
      send_byte(hdr[k]);
    end
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0)
        d = $urandom_range(0, 1) ? ubxfp_pkg::SYNC_FIRST : ubxfp_pkg::SYNC_SECOND;
      else
        d = 8'($urandom);
      sa = sa + d;
      sb = sb + sa;
      send_byte(d);
    end
    // spoil one of the check bytes
    if (bad_ck) begin
      if ($urandom_range(0, 1)) sa = sa ^ 8'($urandom_range(1, 255));
      else sb = sb ^ 8'($urandom_range(1, 255));
    end
    send_byte(sa);
    send_byte(sb);
  endtask

  // mix of frames, noise and lone sync bytes up to a byte count
  task automatic send_random_stream(input int target);
    int pick;
    logic [7:0] b;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(8'($urandom), 8'($urandom), 16'($urandom_range(0, 8)),
                   $urandom_range(0, 3) == 0);
      end else if (pick < 85) begin
        // noise outside frames, never a first sync byte
        do b = 8'($urandom); while (b == ubxfp_pkg::SYNC_FIRST);
        send_byte(b);
      end else begin
        // lone sync byte, sometimes twice, then a byte that breaks the pair
        send_byte(ubxfp_pkg::SYNC_FIRST);
        if ($urandom_range(0, 3) == 0) send_byte(ubxfp_pkg::SYNC_FIRST);
        do b = 8'($urandom);
        while (b == ubxfp_pkg::SYNC_FIRST || b == ubxfp_pkg::SYNC_SECOND);
        send_byte(b);
      end
    end
  endtask

  initial begin
    rx.valid = 1'b0;
    rx.rx_byte = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: passthrough extremes, lone sync bytes, empty and bad frames
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ubxfp_pkg::SYNC_SECOND);
    send_byte(ubxfp_pkg::SYNC_FIRST);
    send_byte(8'h00);
    send_byte(ubxfp_pkg::SYNC_FIRST);
    send_frame(8'hFF, 8'h00, 16'd0, 1'b0);
    send_frame(8'h00, 8'hFF, 16'd1, 1'b1);

    // random stream under three back-pressure settings
    send_random_stream(60);
    src_idle_pct = 81;
    snk_idle_pct = 21;
    send_random_stream(100);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random_stream(140);

    // long payload reaches the upper byte of the length and index
    send_frame(8'($urandom), 8'($urandom), 16'h0101, $urandom_range(0, 1) == 1);
    rx.valid <= 1'b0;

    // drain, then settle
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    end_of_stream <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
